FILE: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Operation codes, the side-band record that travels down the divider chain,
// and the saturation helpers used by the front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// Number of quotient bits built by the divider chain, one per cell.
	localparam int unsigned QBITS = 17;

	typedef struct packed {
		logic [15:0] val;
		logic        ovf;
	} sat_t;

	// Everything an item carries next to the divider remainders.
	typedef struct packed {
		logic        is_div;
		logic        dz;
		logic        neg_re;
		logic        neg_im;
		logic [15:0] re;
		logic [15:0] im;
		logic        ovf;
	} side_t;

	// Clamp a signed 33-bit value to the signed 16-bit range.
	function automatic sat_t sat33(input logic signed [32:0] v);
		sat_t r;
		if (v > 33'sd32767) begin
			r.val = 16'h7fff;
			r.ovf = 1'b1;
		end else if (v < -33'sd32768) begin
			r.val = 16'h8000;
			r.ovf = 1'b1;
		end else begin
			r.val = v[15:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	// Apply the sign to a quotient magnitude and clamp it.
	function automatic sat_t sat_quot(input logic [QBITS-1:0] q, input logic neg);
		sat_t r;
		logic [QBITS-1:0] nq;
		nq = QBITS'(~q + 1'b1);
		if (!neg) begin
			if (q > QBITS'(32767)) begin
				r.val = 16'h7fff;
				r.ovf = 1'b1;
			end else begin
				r.val = q[15:0];
				r.ovf = 1'b0;
			end
		end else begin
			if (q > QBITS'(32768)) begin
				r.val = 16'h8000;
				r.ovf = 1'b1;
			end else begin
				r.val = nq[15:0];
				r.ovf = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cau_req_if.sv
// ----------------------------------------------------------------------------
// cau_req_if: operand channel
// Valid/ready channel carrying the operation code and two complex operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] a_re;
	logic signed [15:0] a_im;
	logic signed [15:0] b_re;
	logic signed [15:0] b_im;

	modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
	modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

FILE: rtl/cau_rsp_if.sv
// ----------------------------------------------------------------------------
// cau_rsp_if: result channel
// Valid/ready channel carrying the complex result and its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] res_re;
	logic signed [15:0] res_im;
	logic               overflow;
	logic               div_zero;

	modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
	modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

`default_nettype wire

FILE: rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: products and sums
// Stage 1 forms the six operand products, stage 2 the sums, the finished
// add, subtract and multiply results, and the divider's starting values.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
	parameter int unsigned FRAC_BITS = 8,
	parameter int unsigned RW        = 32 + FRAC_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	cau_req_if.sink           req,
	output logic              valid,
	input  wire               ready,
	output cau_pkg::side_t    side,
	output logic [RW-1:0]     rem_re,
	output logic [RW-1:0]     rem_im,
	output logic [31:0]       den
);

	logic               v_s1, v_s2;
	logic               rdy1, rdy2;
	logic [1:0]         kind_s1;
	logic signed [15:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [31:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;

	cau_pkg::side_t     side_s2;
	logic [RW-1:0]      rem_re_s2, rem_im_s2;
	logic [31:0]        den_s2;

	logic signed [32:0] mr, mi, nr, ni, sr, si;
	logic signed [16:0] s_re, s_im;
	logic [32:0]        mag_r, mag_i;
	logic [31:0]        den_c;
	cau_pkg::sat_t      q_re, q_im;
	cau_pkg::side_t     side_c;

	assign rdy2      = !v_s2 || ready;
	assign rdy1      = !v_s1 || rdy2;
	assign req.ready = rdy1;

	always_comb begin
		mr    = {ac_s1[31], ac_s1} - {bd_s1[31], bd_s1};
		mi    = {ad_s1[31], ad_s1} + {bc_s1[31], bc_s1};
		nr    = {ac_s1[31], ac_s1} + {bd_s1[31], bd_s1};
		ni    = {bc_s1[31], bc_s1} - {ad_s1[31], ad_s1};
		den_c = cc_s1 + dd_s1;
		mag_r = nr[32] ? 33'(-nr) : nr;
		mag_i = ni[32] ? 33'(-ni) : ni;
		s_re  = {a_s1[15], a_s1} + {c_s1[15], c_s1};
		s_im  = {b_s1[15], b_s1} + {d_s1[15], d_s1};
		sr    = 33'(s_re);
		si    = 33'(s_im);
		unique case (kind_s1)
			cau_pkg::KIND_ADD: begin
				sr = {{16{s_re[16]}}, s_re};
				si = {{16{s_im[16]}}, s_im};
			end
			cau_pkg::KIND_SUB: begin
				s_re = {a_s1[15], a_s1} - {c_s1[15], c_s1};
				s_im = {b_s1[15], b_s1} - {d_s1[15], d_s1};
				sr   = {{16{s_re[16]}}, s_re};
				si   = {{16{s_im[16]}}, s_im};
			end
			cau_pkg::KIND_MUL: begin
				sr = mr >>> FRAC_BITS;
				si = mi >>> FRAC_BITS;
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
		q_re          = cau_pkg::sat33(sr);
		q_im          = cau_pkg::sat33(si);
		side_c.is_div = (kind_s1 == cau_pkg::KIND_DIV);
		side_c.dz     = (den_c == 32'd0);
		side_c.neg_re = nr[32];
		side_c.neg_im = ni[32];
		side_c.re     = q_re.val;
		side_c.im     = q_im.val;
		side_c.ovf    = q_re.ovf | q_im.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			kind_s1 <= req.kind;
			a_s1    <= req.a_re;
			b_s1    <= req.a_im;
			c_s1    <= req.b_re;
			d_s1    <= req.b_im;
			ac_s1   <= req.a_re * req.b_re;
			bd_s1   <= req.a_im * req.b_im;
			ad_s1   <= req.a_re * req.b_im;
			bc_s1   <= req.a_im * req.b_re;
			cc_s1   <= req.b_re * req.b_re;
			dd_s1   <= req.b_im * req.b_im;
		end
		if (rdy2 && v_s1) begin
			side_s2   <= side_c;
			rem_re_s2 <= RW'(mag_r[31:0]) << FRAC_BITS;
			rem_im_s2 <= RW'(mag_i[31:0]) << FRAC_BITS;
			den_s2    <= den_c;
		end
	end

	assign valid  = v_s2;
	assign side   = side_s2;
	assign rem_re = rem_re_s2;
	assign rem_im = rem_im_s2;
	assign den    = den_s2;

endmodule

`default_nettype wire

FILE: rtl/cau_cell.sv
// ----------------------------------------------------------------------------
// cau_cell: one restoring-division step
// Tests both remainders against the divisor shifted by POS, keeps one
// quotient bit for each part and hands everything to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_cell #(
	parameter int unsigned RW  = 40,
	parameter int unsigned POS = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire cau_pkg::side_t          in_side,
	input  wire [RW-1:0]                 in_rem_re,
	input  wire [RW-1:0]                 in_rem_im,
	input  wire [31:0]                   in_den,
	input  wire [cau_pkg::QBITS-1:0]     in_q_re,
	input  wire [cau_pkg::QBITS-1:0]     in_q_im,
	output logic                         out_valid,
	input  wire                          out_ready,
	output cau_pkg::side_t               out_side,
	output logic [RW-1:0]                out_rem_re,
	output logic [RW-1:0]                out_rem_im,
	output logic [31:0]                  out_den,
	output logic [cau_pkg::QBITS-1:0]    out_q_re,
	output logic [cau_pkg::QBITS-1:0]    out_q_im
);

	localparam int unsigned CW = RW + cau_pkg::QBITS + 1;

	logic                      v_q;
	cau_pkg::side_t            side_q;
	logic [RW-1:0]             rem_re_q, rem_im_q;
	logic [31:0]               den_q;
	logic [cau_pkg::QBITS-1:0] q_re_q, q_im_q;

	logic [CW-1:0] dshift, dif_re, dif_im;
	logic          ge_re, ge_im;

	always_comb begin
		dshift = CW'(in_den) << POS;
		dif_re = CW'(in_rem_re) - dshift;
		dif_im = CW'(in_rem_im) - dshift;
		ge_re  = !dif_re[CW-1];
		ge_im  = !dif_im[CW-1];
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			side_q   <= in_side;
			den_q    <= in_den;
			rem_re_q <= ge_re ? dif_re[RW-1:0] : in_rem_re;
			rem_im_q <= ge_im ? dif_im[RW-1:0] : in_rem_im;
			q_re_q   <= {in_q_re[cau_pkg::QBITS-2:0], ge_re};
			q_im_q   <= {in_q_im[cau_pkg::QBITS-2:0], ge_im};
		end
	end

	assign out_valid  = v_q;
	assign out_side   = side_q;
	assign out_rem_re = rem_re_q;
	assign out_rem_im = rem_im_q;
	assign out_den    = den_q;
	assign out_q_re   = q_re_q;
	assign out_q_im   = q_im_q;

endmodule

`default_nettype wire

FILE: rtl/cau_out.sv
// ----------------------------------------------------------------------------
// cau_out: result register
// Picks the direct result, zero for a zero divisor, or the signed, clamped
// quotient and holds it on the result channel until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_out (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire cau_pkg::side_t       in_side,
	input  wire [cau_pkg::QBITS-1:0]  in_q_re,
	input  wire [cau_pkg::QBITS-1:0]  in_q_im,
	cau_rsp_if.source                 rsp
);

	logic          v_q;
	logic [15:0]   re_q, im_q;
	logic          ovf_q, dz_q;
	cau_pkg::sat_t qr, qi;

	assign qr       = cau_pkg::sat_quot(in_q_re, in_side.neg_re);
	assign qi       = cau_pkg::sat_quot(in_q_im, in_side.neg_im);
	assign in_ready = !v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (!in_side.is_div) begin
				re_q  <= in_side.re;
				im_q  <= in_side.im;
				ovf_q <= in_side.ovf;
				dz_q  <= 1'b0;
			end else if (in_side.dz) begin
				re_q  <= '0;
				im_q  <= '0;
				ovf_q <= 1'b0;
				dz_q  <= 1'b1;
			end else begin
				re_q  <= qr.val;
				im_q  <= qi.val;
				ovf_q <= qr.ovf | qi.ovf;
				dz_q  <= 1'b0;
			end
		end
	end

	assign rsp.valid    = v_q;
	assign rsp.res_re   = re_q;
	assign rsp.res_im   = im_q;
	assign rsp.overflow = ovf_q;
	assign rsp.div_zero = dz_q;

endmodule

`default_nettype wire

FILE: rtl/complex_arith_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top: complex add, subtract, multiply and divide
// Signed fixed-point complex ALU with saturation, built as a product/sum
// front end, a chain of restoring-division cells and a result register.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------------
//   req     | in        | kind, a_re, a_im, b_re, b_im
//   rsp     | out       | res_re, res_im, overflow, div_zero
//
// One item is accepted per cycle unless the pipeline is stalled; every item,
// whatever its kind, passes through 20 registers: two front-end stages, one
// cell per quotient bit (17 cells) and the output register.
// Each stage has its own valid bit and stalls only when the stage after it
// is full and stalled, so bubbles close up behind a stalled result.
// Reset clears only the valid bits; the datapath registers carry no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit_top #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	cau_req_if.sink    req,
	cau_rsp_if.source  rsp
);

	// Remainder width: a 32-bit numerator magnitude scaled by the fraction.
	localparam int unsigned RW = 32 + FRAC_BITS;
	localparam int unsigned NC = cau_pkg::QBITS;

	// Cell k works on quotient bit NC-1-k; index NC is the chain output.
	logic                      c_valid [NC+1];
	logic                      c_ready [NC+1];
	cau_pkg::side_t            c_side  [NC+1];
	logic [RW-1:0]             c_rre   [NC+1];
	logic [RW-1:0]             c_rim   [NC+1];
	logic [31:0]               c_den   [NC+1];
	logic [NC-1:0]             c_qre   [NC+1];
	logic [NC-1:0]             c_qim   [NC+1];

	cau_front #(
		.FRAC_BITS (FRAC_BITS),
		.RW        (RW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.valid  (c_valid[0]),
		.ready  (c_ready[0]),
		.side   (c_side[0]),
		.rem_re (c_rre[0]),
		.rem_im (c_rim[0]),
		.den    (c_den[0])
	);

	// The quotient bits start empty; each cell shifts one in.
	assign c_qre[0] = '0;
	assign c_qim[0] = '0;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		cau_cell #(
			.RW  (RW),
			.POS (NC - 1 - k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (c_valid[k]),
			.in_ready   (c_ready[k]),
			.in_side    (c_side[k]),
			.in_rem_re  (c_rre[k]),
			.in_rem_im  (c_rim[k]),
			.in_den     (c_den[k]),
			.in_q_re    (c_qre[k]),
			.in_q_im    (c_qim[k]),
			.out_valid  (c_valid[k+1]),
			.out_ready  (c_ready[k+1]),
			.out_side   (c_side[k+1]),
			.out_rem_re (c_rre[k+1]),
			.out_rem_im (c_rim[k+1]),
			.out_den    (c_den[k+1]),
			.out_q_re   (c_qre[k+1]),
			.out_q_im   (c_qim[k+1])
		);
	end

	// The final remainders and divisor are not needed past the last cell.
	cau_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (c_valid[NC]),
		.in_ready (c_ready[NC]),
		.in_side  (c_side[NC]),
		.in_q_re  (c_qre[NC]),
		.in_q_im  (c_qim[NC]),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

FILE: sim/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker: result predictor and scoreboard for the complex ALU
// Watches both channels, computes the expected result of every accepted item
// and compares each accepted result against the oldest pending one.
// ----------------------------------------------------------------------------
module cau_checker #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	input  wire         req_ready,
	input  wire  [1:0]  req_kind,
	input  wire  [15:0] req_a_re,
	input  wire  [15:0] req_a_im,
	input  wire  [15:0] req_b_re,
	input  wire  [15:0] req_b_im,
	input  wire         rsp_valid,
	input  wire         rsp_ready,
	input  wire  [15:0] rsp_re,
	input  wire  [15:0] rsp_im,
	input  wire         rsp_ovf,
	input  wire         rsp_dz,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic        ovf;
		logic        dz;
	} cplx_res_t;

	cplx_res_t expected_q[$];

	function automatic logic [15:0] clamp16(input longint v, inout logic ovf);
		if (v > 32767) begin
			ovf = 1'b1;
			return 16'h7fff;
		end
		if (v < -32768) begin
			ovf = 1'b1;
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	function automatic cplx_res_t compute_result(input logic [1:0] kind,
			input logic [15:0] ar, ai, br, bi);
		longint a, b, c, d, re, im, den;
		logic ovf;
		cplx_res_t r;
		a = longint'($signed(ar));
		b = longint'($signed(ai));
		c = longint'($signed(br));
		d = longint'($signed(bi));
		re = 0;
		im = 0;
		ovf = 1'b0;
		r.dz = 1'b0;
		case (kind)
			cau_pkg::KIND_ADD: begin
				re = a + c;
				im = b + d;
			end
			cau_pkg::KIND_SUB: begin
				re = a - c;
				im = b - d;
			end
			cau_pkg::KIND_MUL: begin
				re = (a * c - b * d) >>> FRAC_BITS;
				im = (a * d + b * c) >>> FRAC_BITS;
			end
			default: begin
				den = c * c + d * d;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					// SystemVerilog division truncates toward zero.
					re = ((a * c + b * d) <<< FRAC_BITS) / den;
					im = ((b * c - a * d) <<< FRAC_BITS) / den;
				end
			end
		endcase
		r.re = clamp16(re, ovf);
		r.im = clamp16(im, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cplx_res_t exp_r;
		if (!arst_n) begin
			mismatches <= 0;
			pending <= 0;
			results_seen <= 0;
			expected_q.delete();
		end else begin
			if (req_valid && req_ready)
				expected_q.push_back(compute_result(req_kind, req_a_re, req_a_im,
					req_b_re, req_b_im));
			if (rsp_valid && rsp_ready) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result re=%h im=%h", $realtime,
							rsp_re, rsp_im);
					mismatches <= mismatches + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.re !== rsp_re || exp_r.im !== rsp_im ||
							exp_r.ovf !== rsp_ovf || exp_r.dz !== rsp_dz) begin
						if (mismatches < 10)
							$display("%0t: mismatch exp re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
								$realtime, exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz,
								rsp_re, rsp_im, rsp_ovf, rsp_dz);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

FILE: sim/complex_arith_unit_top_tb.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top_tb: testbench for the complex arithmetic unit
// Drives directed corner operands, then random items of every kind with
// random gaps on both channels, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module complex_arith_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 20;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cau_req_if req();
	cau_rsp_if rsp();

	int mismatches, pending, results_seen;
	int send_idle_pct = 34;
	int recv_idle_pct = 78;
	bit hold_off = 1'b0;
	int idle_cycles = 0;
	int items_sent = 0;

	always #5 clk = ~clk;

	complex_arith_unit_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	cau_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_kind(req.kind),
		.req_a_re(req.a_re), .req_a_im(req.a_im),
		.req_b_re(req.b_re), .req_b_im(req.b_im),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_re(rsp.res_re), .rsp_im(rsp.res_im),
		.rsp_ovf(rsp.overflow), .rsp_dz(rsp.div_zero),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		req.valid = 1'b0;
		req.kind = cau_pkg::KIND_ADD;
		req.a_re = '0;
		req.a_im = '0;
		req.b_re = '0;
		req.b_im = '0;
		rsp.ready = 1'b0;
	end

	// The result side stalls at random; during a hold-off it stays low so the
	// pipeline fills completely and back-pressures the operand channel.
	always @(posedge clk) begin
		if (hold_off)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// The watchdog counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.", pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Random operand value: a third full range, a third extremes and a third small
	// values, so that saturation and near-zero divisors are both common.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(1024)) - 512);
			3: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offers one item and holds it until it is accepted; the sender's gap is
	// inserted before the item is offered, so valid never drops mid-burst.
	task automatic send_item(input logic [1:0] kind, input logic [15:0] ar, ai, br, bi);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.a_re <= ar;
		req.a_im <= ai;
		req.b_re <= br;
		req.b_im <= bi;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_items(input int count);
		for (int i = 0; i < count; i++)
			send_item(2'($urandom_range(3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
	endtask

	initial begin
		logic [1:0] k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every kind with the extremes of the operand range,
		// a zero divisor, and the most negative quotient and product.
		for (int kk = 0; kk < 4; kk++) begin
			k = 2'(kk);
			send_item(k, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
			send_item(k, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_item(k, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
			send_item(k, 16'h0100, 16'hff00, 16'h0000, 16'h0000);
			send_item(k, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
		end
		send_item(cau_pkg::KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(cau_pkg::KIND_DIV, 16'h8000, 16'h0000, 16'h0100, 16'h0000);
		send_item(cau_pkg::KIND_DIV, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
		send_item(cau_pkg::KIND_MUL, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
		send_item(cau_pkg::KIND_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);

		// Sender pauses until the pipeline has delivered everything.
		drain_results();

		random_items(280);

		// Long receiver hold-off while the sender keeps offering items.
		hold_off = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			random_items(40);
		join

		send_idle_pct = 78;
		recv_idle_pct = 34;
		random_items(260);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(250);

		drain_results();
		repeat (LATENCY + 5) @(posedge clk);

		$display("Sent %0d items of all four kinds, checked %0d results,", items_sent,
			results_seen);
		$display("including saturation, zero divisors and a full back-pressure stall.");
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cau_pkg.sv
rtl/cau_req_if.sv
rtl/cau_rsp_if.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/cau_out.sv
rtl/complex_arith_unit_top.sv
sim/cau_checker.sv
sim/complex_arith_unit_top_tb.sv
